[src/sat_pkg.sv]
// Shared constants, codes and types of the sorted array table.
package sat_pkg;

    localparam int CAPACITY  = 128;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 7;
    localparam int STAT_W    = 3;
    localparam int OUT_POS_W = 7;
    localparam int OUT_CNT_W = 8;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 2'd0,
        FN_DELETE  = 2'd1,
        FN_SEARCH  = 2'd2,
        FN_REVERSE = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

endpackage

[src/sat_ram.sv]
// Generic simple dual-port RAM with registered read.
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[src/sorted_array_table.sv]
// Sorted array table: insert, delete, search and reverse on a packed table.
// Input channel i_valid / o_stall carries one request: i_func, i_value,
// i_position. It is taken at an edge where i_valid is high and o_stall low.
// Output channel o_valid / i_stall returns one result per request: o_status,
// o_found_position, o_count_after. The result register holds while i_stall
// is high; a new request may be taken while an old result still waits.
// Each request that is not refused walks the table in one RAM (one read and
// one write port, registered read). Insert, search and delete stream one
// entry per cycle (delete from the given position). Reverse swaps one pair
// of entries at a time, from both ends inward. Full, empty and bad-position
// refusals go straight to the result without touching the table. o_stall is
// high from acceptance until the result is loaded into the output register.
// Synchronous reset empties the table (count zero) and drops any pending
// result; table contents are not cleared and need no clearing pass.
module sorted_array_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sat_pkg::FUNC_W-1:0]      i_func,
    input  logic signed [sat_pkg::DATA_W-1:0] i_value,
    input  logic [sat_pkg::POS_W-1:0]       i_position,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sat_pkg::STAT_W-1:0]      o_status,
    output logic [sat_pkg::OUT_POS_W-1:0]   o_found_position,
    output logic [sat_pkg::OUT_CNT_W-1:0]   o_count_after
);
    import sat_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REV, S_FIN} t_state;

    t_state                    r_state;
    t_func                     r_func;
    logic signed [DATA_W-1:0]  r_val;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_rd_idx;
    logic                      r_rd_vld;
    logic [IDX_W-1:0]          r_dat_idx;
    logic                      r_ins;
    logic [DATA_W-1:0]         r_carry;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_hit_idx;
    logic [IDX_W-1:0]          r_lo;
    logic [IDX_W-1:0]          r_hi;
    logic [IDX_W-1:0]          r_plo;
    logic [IDX_W-1:0]          r_phi;
    logic                      r_pend;
    logic                      r_phase;
    logic [DATA_W-1:0]         r_tmp;
    t_status                   r_res_status;
    logic [OUT_POS_W-1:0]      r_res_found;
    logic [CNT_W-1:0]          r_res_count;
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [OUT_POS_W-1:0]      r_out_found;
    logic [OUT_CNT_W-1:0]      r_out_count;

    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic [DATA_W-1:0]         w_wdata;
    logic                      w_re;
    logic [IDX_W-1:0]          w_raddr;
    logic [DATA_W-1:0]         w_rdata;
    logic                      w_rd_go;
    logic                      w_scan_done;
    logic                      w_pair;
    logic                      w_less;
    logic [CMP_W-1:0]          w_pos_ext;
    logic [CMP_W-1:0]          w_pos_next;
    logic                      w_accept;
    logic                      w_load;

    sat_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign w_rd_go     = (r_rd_idx < r_count);
    assign w_scan_done = !w_rd_go && !r_rd_vld;
    assign w_pair      = (r_lo < r_hi);
    assign w_less      = (r_val < $signed(w_rdata));
    assign w_pos_ext   = CMP_W'(i_position);
    assign w_pos_next  = w_pos_ext + CMP_W'(1);
    assign w_load      = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_carry;
        w_re    = 1'b0;
        w_raddr = '0;
        unique case (r_state)
            S_SCAN: begin
                w_re    = w_rd_go;
                w_raddr = r_rd_idx[IDX_W-1:0];
                if (r_rd_vld) begin
                    if (r_func == FN_INSERT) begin
                        if (r_ins) begin
                            w_we    = 1'b1;
                            w_waddr = r_dat_idx;
                            w_wdata = r_carry;
                        end else if (w_less) begin
                            w_we    = 1'b1;
                            w_waddr = r_dat_idx;
                            w_wdata = r_val;
                        end
                    end else if (r_func == FN_DELETE) begin
                        w_we    = 1'b1;
                        w_waddr = r_dat_idx - IDX_W'(1);
                        w_wdata = w_rdata;
                    end
                end
                if (w_scan_done && r_func == FN_INSERT) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = r_ins ? r_carry : r_val;
                end
            end
            S_REV: begin
                w_re = w_pair;
                if (!r_phase) begin
                    w_raddr = r_lo;
                    w_we    = r_pend;
                    w_waddr = r_plo;
                    w_wdata = w_rdata;
                end else begin
                    w_raddr = r_hi;
                    w_we    = r_pend;
                    w_waddr = r_phi;
                    w_wdata = r_tmp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_ins       <= 1'b0;
            r_hit       <= 1'b0;
            r_pend      <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func       <= t_func'(i_func);
                        r_val        <= i_value;
                        r_res_status <= ST_OK;
                        r_res_found  <= '0;
                        r_res_count  <= r_count;
                        r_rd_vld     <= 1'b0;
                        r_ins        <= 1'b0;
                        r_hit        <= 1'b0;
                        r_pend       <= 1'b0;
                        r_phase      <= 1'b0;
                        r_rd_idx     <= '0;
                        unique case (t_func'(i_func))
                            FN_INSERT: begin
                                if (r_count >= CNT_W'(CAPACITY)) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            FN_DELETE: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_FIN;
                                end else if (w_pos_ext >= CMP_W'(r_count)) begin
                                    r_res_status <= ST_BADPOS;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_rd_idx <= CNT_W'(w_pos_next);
                                    r_state  <= S_SCAN;
                                end
                            end
                            FN_SEARCH: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            FN_REVERSE: begin
                                r_lo    <= '0;
                                r_hi    <= (r_count == '0) ? '0
                                           : IDX_W'(r_count - CNT_W'(1));
                                r_state <= S_REV;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= w_rd_go;
                    if (w_rd_go) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_dat_idx <= r_rd_idx[IDX_W-1:0];
                    end
                    if (r_rd_vld) begin
                        if (r_func == FN_INSERT && (r_ins || w_less)) begin
                            r_ins   <= 1'b1;
                            r_carry <= w_rdata;
                        end
                        if (r_func == FN_SEARCH && !r_hit && $signed(w_rdata) == r_val) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_dat_idx;
                        end
                    end
                    if (w_scan_done) begin
                        r_state <= S_FIN;
                        if (r_func == FN_INSERT) begin
                            r_count     <= r_count + CNT_W'(1);
                            r_res_count <= r_count + CNT_W'(1);
                        end else if (r_func == FN_DELETE) begin
                            r_count     <= r_count - CNT_W'(1);
                            r_res_count <= r_count - CNT_W'(1);
                        end else if (r_hit) begin
                            r_res_found <= OUT_POS_W'(r_hit_idx);
                        end else begin
                            r_res_status <= ST_NOTFOUND;
                        end
                    end
                end
                S_REV: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_pend <= w_pair;
                        if (w_pair) begin
                            r_tmp <= w_rdata;
                            r_plo <= r_lo;
                            r_phi <= r_hi;
                            r_lo  <= r_lo + IDX_W'(1);
                            r_hi  <= r_hi - IDX_W'(1);
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_out_status <= r_res_status;
                        r_out_found  <= r_res_found;
                        r_out_count  <= OUT_CNT_W'(r_res_count);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_count_after    = r_out_count;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("table count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && (w_waddr == w_raddr)))
        else $error("RAM read and write to the same entry");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count_after == OUT_CNT_W'(CAPACITY)))
        else $error("full status with table not full");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without going busy");
`endif

endmodule

[tb/tb.sv]
// Testbench for the sorted array table: directed, full-table, backpressure and random tests.
`timescale 1ns / 100ps

module tb;
    import sat_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 190;

    typedef struct {
        t_status                status;
        logic [OUT_POS_W-1:0]   found_position;
        logic [OUT_CNT_W-1:0]   count_after;
    } t_table_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [FUNC_W-1:0]         i_func = FN_INSERT;
    logic signed [DATA_W-1:0]  i_value = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STAT_W-1:0]         o_status;
    logic [OUT_POS_W-1:0]      o_found_position;
    logic [OUT_CNT_W-1:0]      o_count_after;

    logic signed [DATA_W-1:0]  mirror_entries [CAPACITY];
    int                        mirror_count = 0;
    t_table_result             pending_results [$];
    t_table_result             want;
    int                        error_count = 0;
    int                        cycle_count = 0;
    logic                      idle_on = 1'b1;
    int                        hold_trigger = 0;
    int                        hold_seen = 0;
    int                        hold_left = 0;

    sorted_array_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_count_after    (o_count_after)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Applies one request to the mirror table and returns the result it must produce.
    function automatic t_table_result apply_to_mirror(t_func f, logic signed [DATA_W-1:0] v,
                                                      logic [POS_W-1:0] p);
        t_table_result          res;
        int                     at;
        int                     lo;
        int                     hi;
        logic signed [DATA_W-1:0] tmp;
        res.status = ST_OK;
        res.found_position = '0;
        case (f)
            FN_INSERT: begin
                if (mirror_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    at = mirror_count;
                    for (int i = 0; i < mirror_count; i++) begin
                        if (v < mirror_entries[i]) begin
                            at = i;
                            break;
                        end
                    end
                    for (int i = mirror_count; i > at; i--)
                        mirror_entries[i] = mirror_entries[i-1];
                    mirror_entries[at] = v;
                    mirror_count++;
                end
            end
            FN_DELETE: begin
                if (mirror_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(p) >= mirror_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = p; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i+1];
                    mirror_count--;
                end
            end
            FN_SEARCH: begin
                if (mirror_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_NOTFOUND;
                    for (int i = 0; i < mirror_count; i++) begin
                        if (mirror_entries[i] == v) begin
                            res.status = ST_OK;
                            res.found_position = OUT_POS_W'(i);
                            break;
                        end
                    end
                end
            end
            default: begin
                lo = 0;
                hi = mirror_count - 1;
                while (lo < hi) begin
                    tmp = mirror_entries[lo];
                    mirror_entries[lo] = mirror_entries[hi];
                    mirror_entries[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
        endcase
        res.count_after = OUT_CNT_W'(mirror_count);
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return int'($urandom_range(16)) - 8;
            4:          return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        if (mirror_count > 0 && $urandom_range(1))
            return mirror_entries[$urandom_range(mirror_count - 1)];
        return pick_value();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (mirror_count > 0 && $urandom_range(3) != 0)
            return POS_W'($urandom_range(mirror_count - 1));
        return POS_W'($urandom_range(127));
    endfunction

    task automatic report_mismatch(string field, longint got, longint expected);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, expected);
        error_count++;
    endtask

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(t_func f, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
        while (idle_on && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        i_position <= p;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_to_mirror(f, v, p));
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_found_position !== want.found_position)
                    report_mismatch("found_position", o_found_position, want.found_position);
                if (o_count_after !== want.count_after)
                    report_mismatch("count_after", o_count_after, want.count_after);
            end
        end
    end

    task automatic test_directed();
        send_request(FN_SEARCH, 5, 0);
        send_request(FN_DELETE, 0, 0);
        send_request(FN_DELETE, 0, 127);
        send_request(FN_REVERSE, 0, 0);
        send_request(FN_INSERT, 0, 0);
        send_request(FN_REVERSE, 0, 0);
        send_request(FN_DELETE, 0, 1);
        send_request(FN_INSERT, 32'sh7FFF_FFFF, 127);
        send_request(FN_INSERT, 32'sh8000_0000, 0);
        send_request(FN_INSERT, 0, 0);
        send_request(FN_INSERT, -1, 0);
        send_request(FN_SEARCH, 0, 0);
        send_request(FN_SEARCH, 32'sh7FFF_FFFF, 0);
        send_request(FN_SEARCH, 32'sh8000_0000, 0);
        send_request(FN_SEARCH, 7, 0);
        send_request(FN_REVERSE, 0, 0);
        send_request(FN_SEARCH, 0, 0);
        send_request(FN_SEARCH, 32'sh7FFF_FFFF, 0);
        send_request(FN_INSERT, 1, 0);
        send_request(FN_DELETE, 0, 5);
        send_request(FN_DELETE, 0, 5);
        send_request(FN_DELETE, 0, 0);
        send_request(FN_DELETE, 0, 127);
        send_request(FN_SEARCH, 32'sh8000_0000, 0);
        send_request(FN_REVERSE, 0, 0);
    endtask

    task automatic test_full_table();
        while (mirror_count < CAPACITY)
            send_request(FN_INSERT, pick_value(), POS_W'($urandom_range(127)));
        send_request(FN_INSERT, 32'sh7FFF_FFFF, 0);
        send_request(FN_INSERT, 32'sh8000_0000, 0);
        send_request(FN_SEARCH, mirror_entries[CAPACITY-1], 0);
        send_request(FN_SEARCH, pick_value(), 0);
        send_request(FN_REVERSE, 0, 0);
        send_request(FN_DELETE, 0, 127);
        send_request(FN_DELETE, 0, 127);
        send_request(FN_DELETE, 0, 0);
        send_request(FN_INSERT, pick_value(), 0);
        send_request(FN_INSERT, pick_value(), 0);
        while (mirror_count > 40)
            send_request(FN_DELETE, 0, pick_position());
    endtask

    // Receiver holds off while requests keep coming; the block must stall its input.
    task automatic test_backpressure();
        hold_trigger <= hold_trigger + 1;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0)
                send_request(FN_INSERT, pick_value(), 0);
            else
                send_request(FN_SEARCH, pick_key(), 0);
        end
    endtask

    task automatic test_random();
        int insert_pct;
        int roll;
        idle_on <= 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 120)
                idle_on <= 1'b1;
            insert_pct = ((n / 75) % 2 == 0) ? 60 : 20;
            roll = $urandom_range(99);
            if (roll < insert_pct)
                send_request(FN_INSERT, pick_value(), POS_W'($urandom_range(127)));
            else if (roll < insert_pct + (90 - insert_pct) / 2)
                send_request(FN_DELETE, pick_value(), pick_position());
            else if (roll < 90)
                send_request(FN_SEARCH, pick_key(), POS_W'($urandom_range(127)));
            else
                send_request(FN_REVERSE, pick_value(), POS_W'($urandom_range(127)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
